// ===== rtl/binary_to_seven_segment_scan_core_defines.svh =====
// assertion macros for the seven-segment scan core
// no dependencies; taken in by the top level
`ifndef BINARY_TO_SEVEN_SEGMENT_SCAN_CORE_DEFINES_SVH
`define BINARY_TO_SEVEN_SEGMENT_SCAN_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define BSCAN_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSCAN_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define BSCAN_ASSERT_LAT(lbl, clk_s, rstn_s, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> ##(n) (cons)) \
		else $error(msg);

`else

`define BSCAN_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define BSCAN_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)
`define BSCAN_ASSERT_LAT(lbl, clk_s, rstn_s, ante, n, cons, msg)

`endif

`endif

// ===== rtl/bscan_pkg.sv =====
// shared types, field widths and the segment table of the scan core
// no dependencies
package bscan_pkg;

	localparam int DIGIT_W   = 4;
	localparam int STEP_BITS = 4;
	localparam int SEG_W     = 8;
	localparam int POS_W     = 3;
	localparam int ANODE_W   = 5;
	localparam int SCAN_SLOTS = 1 << POS_W;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [SEG_W-1:0]   seg_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [ANODE_W-1:0] anode_t;

	localparam seg_t SEG_BLANK = 8'hFF;

	// active-low cathodes, bit order dp,G,A,B,D,F,E,C
	function automatic seg_t seg_pattern(input digit_t d);
		seg_t s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hEE;
			4'd2: s = 8'h85;
			4'd3: s = 8'h86;
			4'd4: s = 8'hAA;
			4'd5: s = 8'h92;
			4'd6: s = 8'h90;
			4'd7: s = 8'hCA;
			4'd8: s = 8'h80;
			4'd9: s = 8'h82;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/bscan_dabble_stage.sv =====
// one registered shift-and-add-3 stage of the binary to bcd pipeline
// depends on bscan_pkg
module bscan_dabble_stage #(
	parameter int DIGIT_COUNT = 5,
	parameter int BIN_W       = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_vld,
	input  logic [DIGIT_COUNT*bscan_pkg::DIGIT_W-1:0]  in_bcd,
	input  logic [BIN_W-1:0]                           in_bin,
	output logic                                       out_vld,
	output logic [DIGIT_COUNT*bscan_pkg::DIGIT_W-1:0]  out_bcd,
	output logic [BIN_W-1:0]                           out_bin
);

	localparam int BCD_W = DIGIT_COUNT * bscan_pkg::DIGIT_W;

	logic [BCD_W-1:0] bcd_c;
	logic [BIN_W-1:0] bin_c;
	logic             vld_s;
	logic [BCD_W-1:0] bcd_s;
	logic [BIN_W-1:0] bin_s;

	// several bits of conversion; carries out of the top digit are dropped
	always_comb begin
		bcd_c = in_bcd;
		bin_c = in_bin;
		for (int s = 0; s < bscan_pkg::STEP_BITS; s++) begin
			for (int d = 0; d < DIGIT_COUNT; d++) begin
				if (bcd_c[d*bscan_pkg::DIGIT_W +: bscan_pkg::DIGIT_W] >= 4'd5) begin
					bcd_c[d*bscan_pkg::DIGIT_W +: bscan_pkg::DIGIT_W] =
						bcd_c[d*bscan_pkg::DIGIT_W +: bscan_pkg::DIGIT_W] + 4'd3;
				end
			end
			{bcd_c, bin_c} = {bcd_c[BCD_W-2:0], bin_c, 1'b0};
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else begin
			vld_s <= in_vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		bcd_s <= bcd_c;
		bin_s <= bin_c;
	end

	assign out_vld = vld_s;
	assign out_bcd = bcd_s;
	assign out_bin = bin_s;

endmodule

// ===== rtl/binary_to_seven_segment_scan_core.sv =====
// top level of the binary to seven-segment scan core
// depends on bscan_pkg, bscan_dabble_stage and the assertion macro header
//
//  channel   handshake          payload
//  -------   ---------          -------
//  input     start / busy       value
//  result    strobe             segments, digit_position, anode_select, last
//
// an item is taken when start is high and busy is low; busy then stays high
// while the issue counter counts down, so items are spaced to match the
// single result port, which gives one digit per cycle.
// the first digit appears after a capture stage, ceil(VALUE_WIDTH/4)
// conversion stages and the scan control register; the digits then follow
// in consecutive cycles.
// reset clears the valid bits, the issue counter and the scan counter.
// the receiver cannot stall, so the pipeline advances every cycle.
`include "binary_to_seven_segment_scan_core_defines.svh"

module binary_to_seven_segment_scan_core #(
	parameter int DIGIT_COUNT = 5,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [VALUE_WIDTH-1:0]          value,
	output logic                            strobe,
	output logic [bscan_pkg::SEG_W-1:0]     segments,
	output logic [bscan_pkg::POS_W-1:0]     digit_position,
	output logic [bscan_pkg::ANODE_W-1:0]   anode_select,
	output logic                            last
);

	localparam int NUM_STAGES = (VALUE_WIDTH + bscan_pkg::STEP_BITS - 1) / bscan_pkg::STEP_BITS;
	localparam int PAD_W      = NUM_STAGES * bscan_pkg::STEP_BITS;
	localparam int BCD_W      = DIGIT_COUNT * bscan_pkg::DIGIT_W;
	localparam int GAP_W      = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int LAT_CYC    = NUM_STAGES + 2;

	localparam bscan_pkg::pos_t LAST_POS = bscan_pkg::pos_t'(DIGIT_COUNT - 1);

	logic                          accept;
	logic [GAP_W-1:0]              gap_q;
	logic                          cap_vld_s1;
	logic [PAD_W-1:0]              cap_val_s1;
	logic                          pipe_vld [0:NUM_STAGES];
	logic [BCD_W-1:0]              pipe_bcd [0:NUM_STAGES];
	logic [PAD_W-1:0]              pipe_bin [0:NUM_STAGES];
	logic [BCD_W-1:0]              sh_q;
	bscan_pkg::pos_t               pos_q;
	logic                          act_q;
	logic [bscan_pkg::SCAN_SLOTS-1:0] onehot;

	assign accept = start && !busy;
	assign busy   = (gap_q != '0);

	// issue spacing: one item per run of digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= GAP_W'(DIGIT_COUNT - 1);
		end else if (gap_q != '0) begin
			gap_q <= gap_q - 1'b1;
		end
	end

	// capture stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_vld_s1 <= 1'b0;
		end else begin
			cap_vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cap_val_s1 <= PAD_W'(value);
		end
	end

	assign pipe_vld[0] = cap_vld_s1;
	assign pipe_bcd[0] = '0;
	assign pipe_bin[0] = cap_val_s1;

	// conversion pipeline, a nibble of the value per stage
	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
		bscan_dabble_stage #(
			.DIGIT_COUNT (DIGIT_COUNT),
			.BIN_W       (PAD_W)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (pipe_vld[g]),
			.in_bcd  (pipe_bcd[g]),
			.in_bin  (pipe_bin[g]),
			.out_vld (pipe_vld[g+1]),
			.out_bcd (pipe_bcd[g+1]),
			.out_bin (pipe_bin[g+1])
		);
	end

	// scan control: load on a finished conversion, then one digit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			pos_q <= '0;
		end else if (pipe_vld[NUM_STAGES]) begin
			act_q <= 1'b1;
			pos_q <= '0;
		end else if (act_q) begin
			if (pos_q == LAST_POS) begin
				act_q <= 1'b0;
			end
			pos_q <= pos_q + 1'b1;
		end
	end

	// digit shifter, most significant digit at the top
	always_ff @(posedge clk) begin
		if (pipe_vld[NUM_STAGES]) begin
			sh_q <= pipe_bcd[NUM_STAGES];
		end else if (act_q) begin
			sh_q <= sh_q << bscan_pkg::DIGIT_W;
		end
	end

	// result fields
	assign onehot         = bscan_pkg::SCAN_SLOTS'(1) << pos_q;
	assign strobe         = act_q;
	assign segments       = bscan_pkg::seg_pattern(sh_q[BCD_W-1 -: bscan_pkg::DIGIT_W]);
	assign digit_position = pos_q;
	assign anode_select   = ~onehot[bscan_pkg::ANODE_W-1:0];
	assign last           = (pos_q == LAST_POS);

	// checks
	`BSCAN_ASSERT_NXT(a_run_continues, clk, arst_n, strobe && !last, strobe, "run of digits broke off early")
	`BSCAN_ASSERT_NXT(a_pos_steps, clk, arst_n, strobe && !last, digit_position == $past(digit_position) + 3'd1, "digit position did not step by one")
	`BSCAN_ASSERT_LAT(a_first_digit, clk, arst_n, start && !busy, LAT_CYC, strobe && digit_position == '0, "taken item did not start a run on time")
	`BSCAN_ASSERT_IMP(a_bits_used, clk, arst_n, pipe_vld[NUM_STAGES], pipe_bin[NUM_STAGES] == '0, "value bits left over after conversion")

endmodule

// ===== tb/binary_to_seven_segment_scan_core_tb.sv =====
// self-checking testbench for the binary to seven-segment scan core
// depends on bscan_pkg and binary_to_seven_segment_scan_core; drives items at
// the falling edge, checks each digit against its own decimal split at the rising edge
module binary_to_seven_segment_scan_core_tb;

	localparam int DIGITS      = 5;
	localparam int VALUE_BITS  = 16;
	localparam int DRAIN_WAIT  = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 450;
	localparam int PRINT_CAP   = 60;

	typedef struct {
		logic [VALUE_BITS-1:0] value;
		int unsigned           gap;
		bit                    drain;
	} scan_item_t;

	typedef struct {
		bscan_pkg::seg_t   segments;
		bscan_pkg::pos_t   position;
		bscan_pkg::anode_t anode;
		logic              last;
	} digit_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [VALUE_BITS-1:0] value = '0;
	logic                  busy;
	logic                  strobe;
	bscan_pkg::seg_t       segments;
	bscan_pkg::pos_t       digit_position;
	bscan_pkg::anode_t     anode_select;
	logic                  last;

	scan_item_t    value_q[$];
	digit_result_t digit_q[$];
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count = 0;
	logic          took = 1'b0;
	int unsigned   gap_left = 0;
	bit            presenting;

	binary_to_seven_segment_scan_core #(
		.DIGIT_COUNT(DIGITS),
		.VALUE_WIDTH(VALUE_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.strobe        (strobe),
		.segments      (segments),
		.digit_position(digit_position),
		.anode_select  (anode_select),
		.last          (last)
	);

	always #5 clk = ~clk;

	// place weight of each display position, top digit first
	function automatic int unsigned place_weight(input int unsigned k);
		int unsigned w;
		w = 1;
		for (int unsigned i = k + 1; i < DIGITS; i++)
			w = w * 10;
		return w;
	endfunction

	// active-low cathodes, dp,G,A,B,D,F,E,C
	function automatic bscan_pkg::seg_t cathode_code(input int unsigned d);
		bscan_pkg::seg_t s;
		case (d)
			0: s = 8'hC0;
			1: s = 8'hEE;
			2: s = 8'h85;
			3: s = 8'h86;
			4: s = 8'hAA;
			5: s = 8'h92;
			6: s = 8'h90;
			7: s = 8'hCA;
			8: s = 8'h80;
			default: s = 8'h82;
		endcase
		return s;
	endfunction

	// split an accepted value into its digits and queue them
	task automatic predict_digits(input logic [VALUE_BITS-1:0] v);
		digit_result_t r;
		int unsigned   d;
		for (int unsigned k = 0; k < DIGITS; k++) begin
			d = (int'(v) / place_weight(k)) % 10;
			r.segments = cathode_code(d);
			r.position = bscan_pkg::pos_t'(k);
			r.anode    = ~(bscan_pkg::anode_t'(1) << k);
			r.last     = (k == DIGITS - 1);
			digit_q.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
				cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic add_item(input logic [VALUE_BITS-1:0] v, input int unsigned gap,
			input bit drain);
		scan_item_t it;
		it.value = v;
		it.gap   = gap;
		it.drain = drain;
		value_q.push_back(it);
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// random values leaning on the digit boundaries and the top of the range
	function automatic logic [VALUE_BITS-1:0] pick_value();
		int unsigned r;
		int unsigned v;
		r = $urandom_range(0, 99);
		if (r < 45)
			v = $urandom_range(0, 65535);
		else if (r < 60)
			v = $urandom_range(0, 99);
		else if (r < 75)
			v = place_weight($urandom_range(0, 3)) + $urandom_range(0, 4) - 2;
		else if (r < 85)
			v = $urandom_range(60000, 65535);
		else
			v = $urandom_range(0, 6) * 10000 + $urandom_range(0, 9) * 1000
				+ $urandom_range(0, 9) * 100 + $urandom_range(0, 9) * 10
				+ $urandom_range(0, 9);
		return v[VALUE_BITS-1:0];
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// monitor: check digits, then record newly accepted items
	always @(posedge clk) begin
		digit_result_t want;
		if (arst_n && strobe) begin
			if (digit_q.size() == 0) begin
				report_mismatch("digit with nothing pending, position", digit_position, 0);
			end else begin
				want = digit_q.pop_front();
				if (segments !== want.segments)
					report_mismatch("segments", segments, want.segments);
				if (digit_position !== want.position)
					report_mismatch("digit_position", digit_position, want.position);
				if (anode_select !== want.anode)
					report_mismatch("anode_select", anode_select, want.anode);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
		if (arst_n && start && !busy)
			predict_digits(value);
		took <= arst_n && start && !busy;
	end

	// driver: present the head item, honour gaps and drain points
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			value <= '0;
		end else begin
			presenting = start;
			if (presenting && took) begin
				presenting = 1'b0;
				void'(value_q.pop_front());
				if (value_q.size() > 0)
					gap_left = value_q[0].gap;
			end
			if (!presenting && value_q.size() > 0) begin
				if (gap_left > 0)
					gap_left--;
				else if (!(value_q[0].drain && digit_q.size() != 0))
					presenting = 1'b1;
			end
			start <= presenting;
			value <= presenting ? value_q[0].value : VALUE_BITS'($urandom);
		end
	end

	initial begin
		// directed: extremes, boundaries, repeated digits and alternating bit patterns
		add_item(16'd0, 0, 0);
		add_item(16'd65535, 0, 0);
		add_item(16'd1, 0, 0);
		add_item(16'd9, 0, 0);
		add_item(16'd10, 0, 0);
		add_item(16'd99, 0, 0);
		add_item(16'd100, 0, 0);
		add_item(16'd999, 0, 0);
		add_item(16'd1000, 0, 0);
		add_item(16'd9999, 0, 0);
		add_item(16'd10000, 0, 0);
		add_item(16'd59999, 0, 0);
		add_item(16'd60000, 0, 0);
		add_item(16'd12345, 0, 0);
		add_item(16'd54321, 0, 0);
		add_item(16'd11111, 0, 0);
		add_item(16'd22222, 0, 0);
		add_item(16'd33333, 0, 0);
		add_item(16'd44444, 0, 0);
		add_item(16'd55555, 0, 0);
		add_item(16'd17777, 0, 0);
		add_item(16'd28888, 0, 0);
		add_item(16'h5555, 0, 0);
		add_item(16'hAAAA, 0, 0);
		add_item(16'd40960, 0, 1);
		// random part, with a few points where the sender waits for all digits
		for (int i = 0; i < RANDOM_ITEMS; i++)
			add_item(pick_value(), pick_gap(),
				(i == 30) || (i == 200) || (i == 400) || ($urandom_range(0, 99) == 0));

		// reset once at the start
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every item to go in and every digit to come out
		@(posedge clk);
		while (value_q.size() != 0 || digit_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== binary_to_seven_segment_scan_core.f =====
+incdir+rtl
rtl/bscan_pkg.sv
rtl/bscan_dabble_stage.sv
rtl/binary_to_seven_segment_scan_core.sv
tb/binary_to_seven_segment_scan_core_tb.sv
